>>> hdl/smpr_pkg.sv
// ----------------------------------------------------------------------------
// smpr_pkg
// Shared widths, port codes and types of the serial mouse port responder.
// ----------------------------------------------------------------------------
package smpr_pkg;

  // Width of the signed motion accumulators.
  localparam int ACCUM_WIDTH = 16;

  // Opcodes of an input item.
  localparam logic OP_PORT   = 1'b0;
  localparam logic OP_MOTION = 1'b1;

  // Fixed port values for the identification phases and a bad supply.
  localparam logic [7:0] PORT_ID0 = 8'h10;
  localparam logic [7:0] PORT_ID1 = 8'h1B;
  localparam logic [7:0] PORT_ID2 = 8'h0F;
  localparam logic [7:0] PORT_ID3 = 8'h1F;
  localparam logic [7:0] PORT_BAD = 8'hFF;

  // Upper nibble of the data lines with the busy flag set or clear.
  localparam logic [3:0] NIB_BUSY = 4'h1;
  localparam logic [3:0] NIB_IDLE = 4'h0;

  typedef logic signed [ACCUM_WIDTH-1:0] accum_t;

  // Current accumulator contents.
  typedef struct packed {
    accum_t x;
    accum_t y;
  } smpr_axes_t;

  // Update request for the accumulators.
  typedef struct packed {
    logic              add;
    logic              clear;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } smpr_motion_cmd_t;

endpackage

>>> hdl/smpr_if.sv
// ----------------------------------------------------------------------------
// smpr_if
// Valid/ready channels for input items and result items of the responder.
// ----------------------------------------------------------------------------
interface smpr_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic              th_level;
  logic              tr_level;
  logic [3:0]        buttons_n;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;

  modport source (
    output valid, opcode, th_level, tr_level, buttons_n, move_x, move_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, th_level, tr_level, buttons_n, move_x, move_y,
    output ready
  );
endinterface

interface smpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_data;

  modport source (output valid, port_data, input ready);
  modport sink (input valid, port_data, output ready);
endinterface

>>> hdl/smpr_motion.sv
// ----------------------------------------------------------------------------
// smpr_motion
// Saturating signed X and Y motion accumulators.
// ----------------------------------------------------------------------------
module smpr_motion
  import smpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  smpr_motion_cmd_t cmd,
  output smpr_axes_t       axes
);

  localparam accum_t ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam accum_t ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  accum_t acc_x_r, acc_x_nxt;
  accum_t acc_y_r, acc_y_nxt;

  // Add with one guard bit; a guard that disagrees with the sign bit means
  // the sum left the range, and the guard tells which way.
  function automatic accum_t sat_add(input accum_t a, input logic signed [7:0] d);
    logic signed [ACCUM_WIDTH:0] s;
    s = {a[ACCUM_WIDTH-1], a} + {{(ACCUM_WIDTH-7){d[7]}}, d};
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      return s[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX;
    end
    return s[ACCUM_WIDTH-1:0];
  endfunction

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    if (cmd.clear) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
    end else if (cmd.add) begin
      acc_x_nxt = sat_add(acc_x_r, cmd.dx);
      acc_y_nxt = sat_add(acc_y_r, cmd.dy);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
  end

  assign axes.x = acc_x_r;
  assign axes.y = acc_y_r;

endmodule

>>> hdl/smpr_phase.sv
// ----------------------------------------------------------------------------
// smpr_phase
// Handshake phase sequencer, report latch and data line multiplexer.
// ----------------------------------------------------------------------------
module smpr_phase
  import smpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       opcode,
  input  logic       th_level,
  input  logic       tr_level,
  input  logic [3:0] buttons_n,
  input  logic       supply_ok,
  input  smpr_axes_t axes,
  output logic       latch,
  output logic [7:0] port_nxt
);

  typedef enum logic [3:0] {
    PH_ID0, PH_ID1, PH_ID2, PH_ID3, PH_FLAGS, PH_BUTTONS,
    PH_XHI, PH_XLO, PH_YHI, PH_YLO, PH_YLO_HOLD
  } phase_t;

  localparam accum_t MAG_LIMIT = ACCUM_WIDTH'(255);
  localparam accum_t NEG_LIMIT = -MAG_LIMIT;

  phase_t     phase_r, phase_nxt;
  logic       prev_th_r, prev_tr_r;
  logic [3:0] flags_r, flags_nxt;
  logic [7:0] held_x_r, held_x_nxt;
  logic [7:0] held_y_r, held_y_nxt;
  logic       port_step;
  logic [1:0] fx, fy;
  logic [7:0] mag_x, mag_y;

  // Flag bits per axis: sign in bit 0, overflow in bit 1.
  function automatic logic [9:0] latch_axis(input accum_t v);
    if (v > MAG_LIMIT)  return {2'b10, 8'hFF};
    if (!v[ACCUM_WIDTH-1]) return {2'b00, v[7:0]};
    if (v < NEG_LIMIT)  return {2'b11, 8'hFF};
    return {2'b01, v[7:0]};
  endfunction

  assign {fx, mag_x} = latch_axis(axes.x);
  assign {fy, mag_y} = latch_axis(axes.y);

  assign port_step = step && (opcode == OP_PORT);
  assign latch = port_step && supply_ok && !th_level && (phase_r == PH_ID0) && prev_th_r;

  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    if (port_step && supply_ok) begin
      if (th_level) begin
        phase_nxt = PH_ID0;
      end else if (phase_r == PH_ID0) begin
        if (prev_th_r) begin
          phase_nxt  = PH_ID1;
          flags_nxt  = {fy[1], fx[1], fy[0], fx[0]};
          held_x_nxt = mag_x;
          held_y_nxt = mag_y;
        end
      end else if (prev_tr_r != tr_level && phase_r != PH_YLO_HOLD) begin
        phase_nxt = phase_t'(phase_r + 4'd1);
      end
    end
  end

  // Port data as seen after this item has taken effect.
  always_comb begin
    case (phase_nxt)
      PH_ID0:     port_nxt = PORT_ID0;
      PH_ID1:     port_nxt = PORT_ID1;
      PH_ID2:     port_nxt = PORT_ID2;
      PH_ID3:     port_nxt = PORT_ID3;
      PH_FLAGS:   port_nxt = {NIB_IDLE, flags_nxt};
      PH_BUTTONS: port_nxt = {NIB_BUSY, ~buttons_n};
      PH_XHI:     port_nxt = {NIB_IDLE, held_x_nxt[7:4]};
      PH_XLO:     port_nxt = {NIB_BUSY, held_x_nxt[3:0]};
      PH_YHI:     port_nxt = {NIB_IDLE, held_y_nxt[7:4]};
      default:    port_nxt = {NIB_BUSY, held_y_nxt[3:0]};
    endcase
    if (!supply_ok) begin
      port_nxt = PORT_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ID0;
      prev_th_r <= 1'b0;
      prev_tr_r <= 1'b0;
      flags_r   <= '0;
      held_x_r  <= '0;
      held_y_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      flags_r  <= flags_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      if (port_step) begin
        prev_th_r <= th_level;
        prev_tr_r <= tr_level;
      end
    end
  end

endmodule

>>> hdl/serial_mouse_port_responder_unit.sv
// ----------------------------------------------------------------------------
// serial_mouse_port_responder_unit
// Game port mouse that answers the host's nibble handshake.
// ----------------------------------------------------------------------------
// The input channel carries one item per access: either a port update with
// the TH and TR line levels and the active-low buttons, or a motion item with
// signed X and Y deltas. Every accepted item produces exactly one result item
// on the output channel, holding the data lines (busy flag in bit 4, nibble
// in bits 3..0). The cfg_we/cfg_wdata port writes the supply register; when
// it is 0 every result reads 0xFF while line levels and motion are still
// tracked.
// An item is captured in an input register, updated against the handshake
// state by one short pass of logic and written to the output register; one
// item is taken every cycle while the receiver takes the results. When the
// receiver stalls, the result is held in the output register and one more
// item may wait in the input register; after that the input ready drops
// until the receiver takes the result.
// Reset clears both registers, the accumulators, the latched report and the
// phase, and sets the supply register to 1.
// ----------------------------------------------------------------------------
module serial_mouse_port_responder_unit
  import smpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  smpr_in_if.sink    in_ch,
  smpr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  // Input register.
  logic              in_valid_r;
  logic              op_r;
  logic              th_r;
  logic              tr_r;
  logic [3:0]        btn_r;
  logic signed [7:0] dx_r;
  logic signed [7:0] dy_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;

  logic             supply_ok_r;
  logic             step;
  logic             latch;
  logic [7:0]       port_nxt;
  smpr_axes_t       axes;
  smpr_motion_cmd_t motion_cmd;

  // The item in the input register moves on when the output register is
  // empty or is being emptied in this cycle.
  assign step        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= in_ch.opcode;
      th_r  <= in_ch.th_level;
      tr_r  <= in_ch.tr_level;
      btn_r <= in_ch.buttons_n;
      dx_r  <= in_ch.move_x;
      dy_r  <= in_ch.move_y;
    end
  end

  // Supply register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_ok_r <= 1'b1;
    end else if (cfg_we) begin
      supply_ok_r <= cfg_wdata;
    end
  end

  // Motion accumulates whatever the supply setting; a latch clears it.
  assign motion_cmd.add   = step && (op_r == OP_MOTION);
  assign motion_cmd.clear = latch;
  assign motion_cmd.dx    = dx_r;
  assign motion_cmd.dy    = dy_r;

  smpr_motion u_motion (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (motion_cmd),
    .axes (axes)
  );

  smpr_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .opcode   (op_r),
    .th_level (th_r),
    .tr_level (tr_r),
    .buttons_n(btn_r),
    .supply_ok(supply_ok_r),
    .axes     (axes),
    .latch    (latch),
    .port_nxt (port_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= port_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.port_data = out_data_r;

  // A bad supply always reads as all ones.
  a_bad_supply: assert property (@(posedge clk) disable iff (!rst_n)
    step && !supply_ok_r |=> out_data_r == PORT_BAD)
    else $error("bad supply did not give all ones");

  // TH high returns the handshake to its first identification nibble.
  a_th_high: assert property (@(posedge clk) disable iff (!rst_n)
    step && op_r == OP_PORT && th_r && supply_ok_r |=> out_data_r == PORT_ID0)
    else $error("TH high did not restart the handshake");

  // A result appears only when an item moved into the output register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(step))
    else $error("result appeared without an item");

  // A latch happens only on a port update, never together with motion.
  a_latch_port: assert property (@(posedge clk) disable iff (!rst_n)
    latch |-> step && op_r == OP_PORT && !motion_cmd.add)
    else $error("latch outside a port update");

endmodule

>>> dv/smpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpr_checker
// Watches both channels and the supply write port, works out the data lines
// that every accepted item must return, and compares each result item with
// the oldest outstanding answer.
// ----------------------------------------------------------------------------
module smpr_checker
  import smpr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  smpr_in_if   in_mon,
  smpr_out_if  out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   mismatch_count,
  output int   answers_pending
);

  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_ID1   = 4'd1;
  localparam logic [3:0] PH_LAST  = 4'd10;

  logic       supply_ok;
  accum_t     acc_x;
  accum_t     acc_y;
  logic [3:0] held_flags;
  logic [7:0] held_x;
  logic [7:0] held_y;
  logic [3:0] phase;
  logic       prev_th;
  logic       prev_tr;
  logic [7:0] port_answer_q[$];

  function automatic accum_t add_clamped(input accum_t a, input logic signed [7:0] d);
    longint hi;
    longint lo;
    longint s;
    hi = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    lo = -hi - 1;
    s  = longint'(a) + longint'(d);
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return accum_t'(s);
  endfunction

  // Returns {overflow, sign} and the byte that the report carries for one axis.
  function automatic logic [1:0] latch_axis(input accum_t v, output logic [7:0] mag);
    if (v > 255) begin
      mag = 8'hFF;
      return 2'b10;
    end
    if (v >= 0) begin
      mag = v[7:0];
      return 2'b00;
    end
    if (v < -255) begin
      mag = 8'hFF;
      return 2'b11;
    end
    mag = v[7:0];
    return 2'b01;
  endfunction

  function automatic logic [7:0] respond_to_item(input logic op, input logic th,
                                                 input logic tr, input logic [3:0] btn,
                                                 input logic signed [7:0] dx,
                                                 input logic signed [7:0] dy);
    logic       old_th;
    logic       old_tr;
    logic       x_over;
    logic       x_sign;
    logic       y_over;
    logic       y_sign;
    logic [7:0] answer;
    if (op == OP_MOTION) begin
      acc_x = add_clamped(acc_x, dx);
      acc_y = add_clamped(acc_y, dy);
    end else begin
      old_th  = prev_th;
      old_tr  = prev_tr;
      prev_th = th;
      prev_tr = tr;
      // A bad supply still records the lines but freezes phase and report.
      if (supply_ok) begin
        if (th) begin
          phase = PH_START;
        end else if (phase == PH_START) begin
          if (old_th) begin
            phase = PH_ID1;
            {x_over, x_sign} = latch_axis(acc_x, held_x);
            {y_over, y_sign} = latch_axis(acc_y, held_y);
            held_flags = {y_over, x_over, y_sign, x_sign};
            acc_x = '0;
            acc_y = '0;
          end
        end else if (old_tr != tr && phase != PH_LAST) begin
          phase = phase + 4'd1;
        end
      end
    end
    case (phase)
      4'd0:    answer = PORT_ID0;
      4'd1:    answer = PORT_ID1;
      4'd2:    answer = PORT_ID2;
      4'd3:    answer = PORT_ID3;
      4'd4:    answer = {NIB_IDLE, held_flags};
      4'd5:    answer = {NIB_BUSY, ~btn};
      4'd6:    answer = {NIB_IDLE, held_x[7:4]};
      4'd7:    answer = {NIB_BUSY, held_x[3:0]};
      4'd8:    answer = {NIB_IDLE, held_y[7:4]};
      default: answer = {NIB_BUSY, held_y[3:0]};
    endcase
    return supply_ok ? answer : PORT_BAD;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      supply_ok      = 1'b1;
      acc_x          = '0;
      acc_y          = '0;
      held_flags     = '0;
      held_x         = '0;
      held_y         = '0;
      phase          = PH_START;
      prev_th        = 1'b0;
      prev_tr        = 1'b0;
      mismatch_count = 0;
      port_answer_q.delete();
    end else begin
      if (cfg_we) supply_ok = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (port_answer_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result item 8'h%02h arrived with no item outstanding",
                     $realtime, out_mon.port_data);
          mismatch_count++;
        end else begin
          want = port_answer_q.pop_front();
          if (out_mon.port_data !== want) begin
            if (mismatch_count < 10)
              $display("%0t: port_data expected 8'h%02h, got 8'h%02h",
                       $realtime, want, out_mon.port_data);
            mismatch_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        port_answer_q.push_back(respond_to_item(in_mon.opcode, in_mon.th_level,
                                                in_mon.tr_level, in_mon.buttons_n,
                                                in_mon.move_x, in_mon.move_y));
    end
    answers_pending = port_answer_q.size();
  end

endmodule

>>> dv/tb_serial_mouse_port_responder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_mouse_port_responder_unit
// Drives the game port mouse with motion items and host handshake sequences,
// flips the supply register between phases and lets the checker compare
// every returned data byte against its own model of the handshake.
// ----------------------------------------------------------------------------
module tb_serial_mouse_port_responder_unit;
  import smpr_pkg::*;

  // The receiver's long hold-off. The block buffers only a couple of items,
  // so this is plenty to see the input ready drop while items keep coming.
  localparam int LONG_HOLD_CYCLES = 60;
  // Slowest correct run: about 1900 items, each with the longest sender gap
  // and receiver stall and its path through the block, plus two long holds
  // and the phase changes; the limit is far above that.
  localparam int CYCLE_LIMIT = 300000;
  // Cycles to wait once nothing is outstanding, to catch stray results.
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  smpr_in_if  in_ch ();
  smpr_out_if out_ch ();

  int   mismatch_count;
  int   answers_pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   bursts_done = 0;

  // Sender idling is only seen by the stimulus process; the receiver's
  // controls are written with nonblocking assignments so that the receiver
  // sees them from the next edge on, whatever the process order.
  logic source_idle_on;
  logic sink_idle_on;
  // Long hold-offs asked for by the stimulus and those the receiver has run.
  int   hold_requests = 0;
  int   holds_served = 0;

  // TR level of the last port update, so that sequences can toggle it.
  logic host_tr = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_mouse_port_responder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  smpr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .answers_pending (answers_pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Receiver: takes result items, with short random stalls when enabled and
  // one long hold-off whenever the stimulus asks for it.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served <= holds_served + 1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one item and returns at the edge that accepts it. Valid is left
  // high unless a random gap follows, so back-to-back items need no toggle.
  task automatic send_item(input logic op, input logic th, input logic tr,
                           input logic [3:0] btn, input logic signed [7:0] dx,
                           input logic signed [7:0] dy);
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.th_level  <= th;
    in_ch.tr_level  <= tr;
    in_ch.buttons_n <= btn;
    in_ch.move_x    <= dx;
    in_ch.move_y    <= dy;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (source_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Deltas lean toward the two extremes so that sums cross the clamp points.
  function automatic logic signed [7:0] pick_delta();
    case ($urandom_range(0, 5))
      0:       return -8'sd128;
      1:       return 8'sd127;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Port update: the motion fields are ignored by the block but still random.
  task automatic port_update(input logic th, input logic tr, input logic [3:0] btn);
    send_item(OP_PORT, th, tr, btn, pick_delta(), pick_delta());
    host_tr = tr;
  endtask

  // Motion item: the line fields are ignored by the block but still random.
  task automatic motion(input logic signed [7:0] dx, input logic signed [7:0] dy);
    send_item(OP_MOTION, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)), dx, dy);
  endtask

  // A long run of full-scale motion that drives both accumulators into
  // saturation, each axis in a random direction.
  task automatic motion_burst();
    logic neg_x;
    logic neg_y;
    neg_x = 1'($urandom_range(0, 1));
    neg_y = 1'($urandom_range(0, 1));
    repeat ($urandom_range(260, 290))
      motion(neg_x ? -8'sd128 : 8'sd127, neg_y ? -8'sd128 : 8'sd127);
    bursts_done++;
  endtask

  // One host read: some motion, TH high, the falling edge that latches the
  // report, then a random number of TR toggles. Short reads are aborted
  // reads; long ones run past the last phase. Motion and repeated levels
  // are mixed in between the toggles.
  task automatic report_read();
    repeat ($urandom_range(0, 4)) motion(pick_delta(), pick_delta());
    repeat ($urandom_range(1, 2))
      port_update(1'b1, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    port_update(1'b0, host_tr, 4'($urandom_range(0, 15)));
    repeat ($urandom_range(0, 12)) begin
      case ($urandom_range(0, 11))
        0, 1:    motion(pick_delta(), pick_delta());
        2:       port_update(1'b0, host_tr, 4'($urandom_range(0, 15)));
        default: port_update(1'b0, !host_tr, 4'($urandom_range(0, 15)));
      endcase
    end
  endtask

  task automatic run_sequence();
    if (bursts_done == 0 || $urandom_range(0, 149) == 0) begin
      motion_burst();
      report_read();
    end else if ($urandom_range(0, 9) < 7) begin
      report_read();
    end else begin
      // Noise: unrelated items with arbitrary line levels.
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1))
          motion(pick_delta(), pick_delta());
        else
          port_update(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Stops offering items and waits until every answer has come back. The
  // count is read at the falling edge, away from the checker's updates.
  task automatic drain_answers();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (answers_pending != 0);
  endtask

  // One phase of the random part: the block is drained, the supply register
  // is written while idle, and then sequences run until the item count of
  // the phase is reached.
  task automatic run_phase(input logic supply, input int n, input logic src_idle,
                           input logic snk_idle, input logic hold);
    int target;
    drain_answers();
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= supply;
    @(posedge clk);
    cfg_we <= 1'b0;
    source_idle_on = src_idle;
    sink_idle_on <= snk_idle;
    if (hold) hold_requests <= hold_requests + 1;
    target = items_sent + n;
    while (items_sent < target) run_sequence();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_PORT;
    in_ch.th_level  <= 1'b0;
    in_ch.tr_level  <= 1'b0;
    in_ch.buttons_n <= 4'hF;
    in_ch.move_x    <= '0;
    in_ch.move_y    <= '0;
    sink_idle_on    <= 1'b1;
    source_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the supply register at its reset value.
    // First read: X sums to exactly 255 and Y to exactly -255, so neither
    // overflows; the TR toggles walk every phase and one more toggle checks
    // that the last phase holds. Buttons alternate all released and all
    // pressed, and the button phase sees all pressed.
    port_update(1'b1, 1'b0, 4'hF);
    motion(8'sd127, -8'sd128);
    motion(8'sd127, -8'sd128);
    motion(8'sd1, 8'sd1);
    port_update(1'b0, 1'b0, 4'h0);
    for (int i = 0; i < 10; i++)
      port_update(1'b0, !host_tr, (i % 2) ? 4'h0 : 4'hF);
    // Second read: X at -256 sets sign and overflow, Y at 257 sets overflow,
    // and the walk stops at the flags nibble before TH goes high again.
    motion(-8'sd128, 8'sd127);
    motion(-8'sd128, 8'sd127);
    motion(8'sd0, 8'sd3);
    port_update(1'b1, host_tr, 4'h0);
    port_update(1'b0, host_tr, 4'hF);
    repeat (3) port_update(1'b0, !host_tr, 4'h5);
    port_update(1'b1, host_tr, 4'hA);

    // Random part. The supply register goes through both values, the first
    // write repeating the reset value; the bad supply phases still track
    // lines and motion, which the following good phase then relies on. The
    // first and fifth phases ask for a long receiver hold-off, and the last
    // phase runs with no idling on either side.
    run_phase(1'b1, 400, 1'b1, 1'b1, 1'b1);
    run_phase(1'b0, 200, 1'b1, 1'b1, 1'b0);
    run_phase(1'b1, 400, 1'b1, 1'b0, 1'b0);
    run_phase(1'b0, 150, 1'b0, 1'b1, 1'b0);
    run_phase(1'b1, 400, 1'b1, 1'b1, 1'b1);
    run_phase(1'b1, 300, 1'b0, 1'b0, 1'b0);

    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && answers_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/smpr_pkg.sv
hdl/smpr_if.sv
hdl/smpr_motion.sv
hdl/smpr_phase.sv
hdl/serial_mouse_port_responder_unit.sv
dv/smpr_checker.sv
dv/tb_serial_mouse_port_responder_unit.sv
